/* hw/rtl/assert_macros.svh */
// Assertion helpers for the verifier RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a property including during reset
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* hw/rtl/totp_pkg.sv */
package totp_pkg;

  localparam int CFG_W = 64;

  localparam logic [1:0] REG_KEY_FIRST  = 2'd0;
  localparam logic [1:0] REG_KEY_MIDDLE = 2'd1;
  localparam logic [1:0] REG_KEY_LAST   = 2'd2;
  localparam logic [1:0] REG_WINDOW     = 2'd3;

  localparam logic [31:0] CODE_MOD = 32'd1000000;
  // ceil(2^51 / CODE_MOD): exact quotient for any 31-bit dividend after >> 51
  localparam logic [31:0] CODE_RECIP = 32'd2251799814;

  localparam logic [159:0] SHA_IV =
    160'h67452301_EFCDAB89_98BADCFE_10325476_C3D2E1F0;

  typedef enum logic [1:0] {
    BLK_INNER_KEY,
    BLK_INNER_MSG,
    BLK_OUTER_KEY,
    BLK_OUTER_MSG
  } blk_sel_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_NEXT,
    ST_CHECK,
    ST_LOAD,
    ST_ROUND,
    ST_FOLD,
    ST_TRUNC,
    ST_MOD,
    ST_CMP,
    ST_DONE
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic     capture;
    logic     init_step;
    logic     adv_step;
    logic     load_blk;
    blk_sel_t blk;
    logic     iv_init;
    logic     round;
    logic     fold;
    logic     save_inner;
    logic     trunc;
    logic     mod_step;
    logic     set_match;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic last_cand;
    logic skip;
    logic round_last;
    logic mod_done;
    logic code_eq;
  } sts_t;

endpackage

/* hw/rtl/totp_datapath.sv */
module totp_datapath #(
  parameter int KEY_BYTES = 20
) (
  input  logic           clk,
  input  logic [63:0]    key_first,
  input  logic [63:0]    key_middle,
  input  logic [31:0]    key_last,
  input  logic [3:0]     window,
  input  logic [63:0]    in_current_step,
  input  logic [19:0]    in_submitted_code,
  input  logic           in_has_last_step,
  input  logic [63:0]    in_last_step,
  input  totp_pkg::cmd_t cmd,
  output totp_pkg::sts_t sts,
  output logic [63:0]    step_o
);
  import totp_pkg::*;

  logic [63:0]  step_r, last_r;
  logic [19:0]  code_r;
  logic         has_r;
  logic [4:0]   cnt_r;
  logic [4:0]   span;
  logic [511:0] w_r;
  logic [159:0] h_r, v_r, ih_r;
  logic [6:0]   rnd_r;
  logic [31:0]  rem_r;
  logic [62:0]  prod_r;
  logic         mod_ph_r;
  logic [159:0] key160;
  logic [511:0] kblk;

  assign span = {window, 1'b0};

  // Build the padded key, masked to the key length
  always_comb begin
    key160 = {key_first, key_middle, key_last};
    for (int i = 0; i < 20; i++) begin
      if (i >= KEY_BYTES) key160[159-8*i -: 8] = 8'h00;
    end
    kblk = {key160, 352'd0};
  end

  // Select the message block for the next compression
  logic [511:0] blk;
  always_comb begin
    case (cmd.blk)
      BLK_INNER_KEY: blk = kblk ^ {64{8'h36}};
      BLK_INNER_MSG: blk = {step_r, 8'h80, 376'd0, 64'd576};
      BLK_OUTER_KEY: blk = kblk ^ {64{8'h5C}};
      BLK_OUTER_MSG: blk = {ih_r, 8'h80, 280'd0, 64'd672};
      default:       blk = '0;
    endcase
  end

  // One SHA-1 round
  logic [31:0] a, b, c, d, e, f, k, t, wn;
  always_comb begin
    {a, b, c, d, e} = v_r;
    if (rnd_r < 7'd20) begin
      f = (b & c) | (~b & d); k = 32'h5A827999;
    end else if (rnd_r < 7'd40) begin
      f = b ^ c ^ d; k = 32'h6ED9EBA1;
    end else if (rnd_r < 7'd60) begin
      f = (b & c) | (b & d) | (c & d); k = 32'h8F1BBCDC;
    end else begin
      f = b ^ c ^ d; k = 32'hCA62C1D6;
    end
    t  = {a[26:0], a[31:27]} + f + e + k + w_r[511:480];
    wn = w_r[95:64] ^ w_r[255:224] ^ w_r[447:416] ^ w_r[511:480];
    wn = {wn[30:0], wn[31]};
  end

  // Dynamic truncation of the MAC
  logic [3:0]  off;
  logic [31:0] trunc;
  always_comb begin
    off   = h_r[3:0];
    trunc = h_r[159 - 8*off -: 32];
    trunc[31] = 1'b0;
  end

  // Reduce by reciprocal multiplication: quotient bits are registered, then the remainder in the next cycle
  logic [11:0] quo;
  logic [31:0] msub;
  assign quo  = prod_r[62:51];
  assign msub = rem_r - {20'd0, quo} * CODE_MOD;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      last_r <= in_last_step;
      code_r <= in_submitted_code;
      has_r  <= in_has_last_step;
    end
    if (cmd.init_step) begin
      step_r <= in_current_step - {60'd0, window};
      cnt_r  <= '0;
    end else if (cmd.adv_step) begin
      step_r <= step_r + 64'd1;
      cnt_r  <= cnt_r + 5'd1;
    end
    if (cmd.iv_init) h_r <= SHA_IV;
    if (cmd.load_blk) begin
      w_r   <= blk;
      v_r   <= cmd.iv_init ? SHA_IV : h_r;
      rnd_r <= '0;
    end else if (cmd.round) begin
      w_r   <= {w_r[479:0], wn};
      v_r   <= {t, a, {b[1:0], b[31:2]}, c, d};
      rnd_r <= rnd_r + 7'd1;
    end
    if (cmd.fold) begin
      h_r <= {h_r[159:128] + v_r[159:128], h_r[127:96] + v_r[127:96],
              h_r[95:64] + v_r[95:64], h_r[63:32] + v_r[63:32],
              h_r[31:0] + v_r[31:0]};
    end
    if (cmd.save_inner) ih_r <= h_r;
    if (cmd.trunc) begin
      rem_r    <= trunc;
      mod_ph_r <= 1'b0;
    end else if (cmd.mod_step) begin
      if (!mod_ph_r) prod_r <= 63'({32'd0, rem_r} * {32'd0, CODE_RECIP});
      else           rem_r  <= msub;
      mod_ph_r <= ~mod_ph_r;
    end
  end

  assign sts.last_cand  = (cnt_r == span);
  assign sts.skip       = has_r && (step_r <= last_r);
  assign sts.round_last = (rnd_r == 7'd79);
  assign sts.mod_done   = mod_ph_r;
  assign sts.code_eq    = (rem_r == {12'd0, code_r});
  assign step_o         = step_r;
endmodule

/* hw/rtl/totp_ctrl.sv */
module totp_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  totp_pkg::sts_t sts,
  output totp_pkg::cmd_t cmd,
  output logic           busy,
  output logic           done,
  output logic           hit
);
  import totp_pkg::*;

  state_t   st_r, st_nxt;
  blk_sel_t blk_r, blk_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= ST_IDLE;
      blk_r <= BLK_INNER_KEY;
    end else begin
      st_r  <= st_nxt;
      blk_r <= blk_nxt;
    end
  end

  always_comb begin
    st_nxt  = st_r;
    blk_nxt = blk_r;
    cmd     = '0;
    cmd.blk = blk_r;
    busy    = (st_r != ST_IDLE);
    done    = 1'b0;
    hit     = 1'b0;
    case (st_r)
      ST_IDLE: if (start) begin
        cmd.capture = 1'b1; cmd.init_step = 1'b1; st_nxt = ST_CHECK;
      end
      ST_NEXT: begin
        if (sts.last_cand) begin
          done = 1'b1; st_nxt = ST_IDLE;
        end else begin
          cmd.adv_step = 1'b1; st_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (sts.skip) st_nxt = ST_NEXT;
        else begin
          blk_nxt = BLK_INNER_KEY; st_nxt = ST_LOAD;
        end
      end
      ST_LOAD: begin
        cmd.load_blk = 1'b1;
        cmd.iv_init  = (blk_r == BLK_INNER_KEY) || (blk_r == BLK_OUTER_KEY);
        st_nxt = ST_ROUND;
      end
      ST_ROUND: begin
        cmd.round = 1'b1;
        if (sts.round_last) st_nxt = ST_FOLD;
      end
      ST_FOLD: begin
        cmd.fold = 1'b1;
        case (blk_r)
          BLK_INNER_KEY: begin blk_nxt = BLK_INNER_MSG; st_nxt = ST_LOAD; end
          BLK_INNER_MSG: begin blk_nxt = BLK_OUTER_KEY; st_nxt = ST_TRUNC; end
          BLK_OUTER_KEY: begin blk_nxt = BLK_OUTER_MSG; st_nxt = ST_LOAD; end
          default:       st_nxt = ST_TRUNC;
        endcase
      end
      ST_TRUNC: begin
        if (blk_r == BLK_OUTER_KEY) begin
          cmd.save_inner = 1'b1; st_nxt = ST_LOAD;
        end else begin
          cmd.trunc = 1'b1; st_nxt = ST_MOD;
        end
      end
      ST_MOD: begin
        cmd.mod_step = 1'b1;
        if (sts.mod_done) st_nxt = ST_CMP;
      end
      ST_CMP: begin
        if (sts.code_eq) st_nxt = ST_DONE;
        else st_nxt = ST_NEXT;
      end
      ST_DONE: begin
        done = 1'b1; hit = 1'b1; st_nxt = ST_IDLE;
      end
      default: st_nxt = ST_IDLE;
    endcase
  end
endmodule

/* hw/rtl/totp_code_verifier_unit.sv */
// Channel | Ports                                  | Handshake
// input   | in_current_step .. in_last_step        | start high, busy low
// result  | out_matched, out_matched_step          | out_valid, one cycle
// config  | cfg_we, cfg_index, cfg_data            | cfg_we, no wait
// Each tried step costs four SHA-1 compressions on the one shared round
// unit, plus the states that check, truncate, reduce and compare.
// A skipped step passes only the check and next states; an item covers 2*window+1 steps.
// The result appears in the cycle after the last step is finished.
// Reset is synchronous; the receiver cannot stall, so results never wait.
`include "assert_macros.svh"
module totp_code_verifier_unit #(
  parameter int KEY_BYTES = 20
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [63:0] in_current_step,
  input  logic [19:0] in_submitted_code,
  input  logic        in_has_last_step,
  input  logic [63:0] in_last_step,
  output logic        out_valid,
  output logic        out_matched,
  output logic [63:0] out_matched_step,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [totp_pkg::CFG_W-1:0] cfg_data
);
  import totp_pkg::*;

  logic [63:0] key_first_r, key_middle_r;
  logic [31:0] key_last_r;
  logic [3:0]  window_r;
  cmd_t        cmd;
  sts_t        sts;
  logic        done, hit;
  logic [63:0] step;

  // Hold configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_first_r  <= '0;
      key_middle_r <= '0;
      key_last_r   <= '0;
      window_r     <= 4'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_KEY_FIRST:  key_first_r  <= cfg_data;
        REG_KEY_MIDDLE: key_middle_r <= cfg_data;
        REG_KEY_LAST:   key_last_r   <= cfg_data[31:0];
        REG_WINDOW:     window_r     <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  totp_ctrl u_ctrl (
    .clk, .rst_n, .start, .sts, .cmd, .busy, .done, .hit
  );

  totp_datapath #(.KEY_BYTES(KEY_BYTES)) u_dp (
    .clk,
    .key_first(key_first_r), .key_middle(key_middle_r), .key_last(key_last_r),
    .window(window_r),
    .in_current_step, .in_submitted_code, .in_has_last_step, .in_last_step,
    .cmd, .sts, .step_o(step)
  );

  // Register the result beat
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else        out_valid <= done;
    if (done) begin
      out_matched      <= hit;
      out_matched_step <= hit ? step : 64'd0;
    end
  end

  `ASSERT_CLK(a_one_beat, clk, rst_n, out_valid |=> !out_valid, "result beat repeated")
  `ASSERT_CLK(a_accept_busy, clk, rst_n, (start && !busy) |=> busy, "accept without busy")
  `ASSERT_CLK(a_done_busy, clk, rst_n, done |-> busy, "done while idle")
  `ASSERT_ALWAYS(a_rst_quiet, clk, !rst_n |=> !out_valid, "result beat after reset")
endmodule
